### rtl/sal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg
// Shared constants for the shifting array list: field widths, operation and
// status codes, default capacity.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

### rtl/sal_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_mem
// Element store: one write port, one read port, registered read data that
// holds until the next read.
// ----------------------------------------------------------------------------
module sal_mem
  import sal_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = DATA_W
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire  [WIDTH-1:0]          wr_data,
  input  wire                       rd_en,
  input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/shifting_array_list.sv
`default_nettype none
// An error gives a single status word through S_RESP; an unused op gives none.
// Insert shifts the entries from the position on one place up, delete those above it
// one place down: one entry moves per cycle through the single read and single write
// port. Traverse: one word a cycle unless m_tready stalls. No new word is accepted
// until the operation completes. Reset clears the entry count, state, pending read
// and output valid; store contents are left as they are.
// ----------------------------------------------------------------------------
// shifting_array_list
// Ordered list of signed 32-bit values with insert, delete and traverse,
// shifting entries one at a time through a small sequencer.
// ----------------------------------------------------------------------------
module shifting_array_list
  import sal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // position[5:0], value[37:6], zero pad[39:38]
  input  wire  [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // data[31:0], status[33:32], count[39:34]
  output logic        m_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_TRAV, S_RESP} state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rem;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       last_addr;
  logic [AW-1:0]       pos_q;
  logic [DATA_W-1:0]   value_q;
  logic                up;
  logic                rd_pend;
  logic                rd_last;
  logic [STAT_W-1:0]   resp_status;
  logic [COUNT_W-1:0]  resp_count;

  logic [DATA_W-1:0]   out_data;
  logic [STAT_W-1:0]   out_status;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                rd_en;
  logic [DATA_W-1:0]   rd_data;

  logic [OP_W-1:0]     in_op;
  logic [POS_W-1:0]    in_pos;
  logic [DATA_W-1:0]   in_value;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       count_ext;
  logic                out_free;
  logic                out_load;
  logic                accept;

  assign in_op     = s_tuser;
  assign in_pos    = s_tdata[POS_W-1:0];
  assign in_value  = s_tdata[POS_W +: DATA_W];
  assign pos_ext   = PW'(in_pos);
  assign count_ext = PW'(count);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (((state == S_TRAV) && rd_pend) || (state == S_RESP));
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  assign m_tdata = {out_count, out_status, out_data};
  assign m_tlast = out_last;

  sal_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // shifted word goes one place up or down from where it was read;
  // the inserted value lands last, once the pipe is empty
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = value_q;
    rd_en   = 1'b0;
    case (state)
      S_SHIFT: begin
        rd_en = (rem != '0);
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = up ? last_addr + 1'b1 : last_addr - 1'b1;
          wr_data = rd_data;
        end else if (rem == '0) begin
          wr_en = up;
        end
      end
      S_TRAV: begin
        rd_en = (rem != '0) && (!rd_pend || out_free);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pos_q   <= AW'(in_pos);
            value_q <= in_value;
            rd_pend <= 1'b0;
            case (in_op)
              OP_TRAVERSE: begin
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  resp_count  <= '0;
                  state       <= S_RESP;
                end else begin
                  idx   <= '0;
                  rem   <= count;
                  state <= S_TRAV;
                end
              end
              OP_INSERT: begin
                resp_count <= COUNT_W'(count);
                if (count_ext >= PW'(CAPACITY)) begin
                  resp_status <= ST_FULL;
                  state       <= S_RESP;
                end else if (pos_ext > count_ext) begin
                  resp_status <= ST_RANGE;
                  state       <= S_RESP;
                end else begin
                  up    <= 1'b1;
                  idx   <= AW'(count - CW'(1));
                  rem   <= CW'(count_ext - pos_ext);
                  state <= S_SHIFT;
                end
              end
              OP_DELETE: begin
                resp_count <= COUNT_W'(count);
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else if (pos_ext >= count_ext) begin
                  resp_status <= ST_RANGE;
                  state       <= S_RESP;
                end else begin
                  up    <= 1'b0;
                  idx   <= AW'(in_pos) + 1'b1;
                  rem   <= CW'(count_ext - pos_ext - PW'(1));
                  state <= S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SHIFT: begin
          if (rem != '0) begin
            idx       <= up ? idx - 1'b1 : idx + 1'b1;
            rem       <= rem - 1'b1;
            last_addr <= idx;
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              count       <= up ? count + 1'b1 : count - 1'b1;
              resp_count  <= up ? COUNT_W'(count + 1'b1) : COUNT_W'(count - 1'b1);
              resp_status <= ST_OK;
              state       <= S_RESP;
            end
          end
        end

        S_TRAV: begin
          if (rd_en) begin
            idx     <= idx + 1'b1;
            rem     <= rem - 1'b1;
            rd_last <= (rem == CW'(1));
            rd_pend <= 1'b1;
          end else if (out_free) begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && out_free) begin
            out_data   <= rd_data;
            out_last   <= rd_last;
            out_status <= ST_OK;
            out_count  <= COUNT_W'(count);
          end
          if (rem == '0 && (!rd_pend || out_free)) begin
            state <= S_IDLE;
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_data   <= '0;
            out_last   <= 1'b1;
            out_status <= resp_status;
            out_count  <= resp_count;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
